>>> rtl/core/dcg_pkg.sv
package dcg_pkg;

    // Request codes carried on the input beat.
    typedef enum logic [1:0] {
        REQ_INIT = 2'd0,
        REQ_CMD  = 2'd1,
        REQ_DATA = 2'd2,
        REQ_GOTO = 2'd3
    } t_req;

    // Controller states: the four timing phases of a bus write, then hand-off.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BEFORE,
        ST_SETUP,
        ST_HIGH,
        ST_AFTER,
        ST_EMIT
    } t_state;

    // Instruction bytes of the display controllers.
    localparam logic [7:0] OP_DISPLAY_ON = 8'h3F;
    localparam logic [7:0] OP_START_LINE = 8'hC0;
    localparam logic [7:0] OP_SET_COLUMN = 8'h40;
    localparam logic [7:0] OP_SET_PAGE   = 8'hB8;

    // Chip select patterns.
    localparam logic [1:0] CS_CHIP1 = 2'b01;
    localparam logic [1:0] CS_CHIP2 = 2'b10;
    localparam logic [1:0] CS_BOTH  = 2'b11;

    // Event kinds.
    localparam logic EV_RESET = 1'b0;
    localparam logic EV_WRITE = 1'b1;

    // Phase lengths in delay units.
    localparam int UNIT_W = 4;
    localparam logic [UNIT_W-1:0] WAIT_BEFORE = 4'd10;
    localparam logic [UNIT_W-1:0] WAIT_SETUP  = 4'd1;
    localparam logic [UNIT_W-1:0] WAIT_HIGH   = 4'd1;
    localparam logic [UNIT_W-1:0] WAIT_AFTER  = 4'd10;

    // Delay unit register.
    localparam int DELAY_W = 16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;

    // Position of an event inside the run of one request.
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_INIT_LAST = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              wait_start;
        logic [UNIT_W-1:0] wait_units;
        logic              emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wait_done;
        logic out_free;
        logic last_event;
    } t_dp_stat;

endpackage

>>> rtl/core/dcg_ctrl.sv
module dcg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output dcg_pkg::t_dp_cmd  o_cmd,
    input  dcg_pkg::t_dp_stat i_stat
);

    dcg_pkg::t_state r_state;
    dcg_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands. The before, setup and high phases
    // each start the next phase's timer in the cycle their own runs out.
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.wait_start = 1'b0;
        o_cmd.wait_units = dcg_pkg::WAIT_BEFORE;
        o_cmd.emit       = 1'b0;
        case (r_state)
            dcg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept     = 1'b1;
                    o_cmd.wait_start = 1'b1;
                    o_cmd.wait_units = dcg_pkg::WAIT_BEFORE;
                    n_state          = dcg_pkg::ST_BEFORE;
                end
            end
            dcg_pkg::ST_BEFORE: begin
                if (i_stat.wait_done) begin
                    o_cmd.wait_start = 1'b1;
                    o_cmd.wait_units = dcg_pkg::WAIT_SETUP;
                    n_state          = dcg_pkg::ST_SETUP;
                end
            end
            dcg_pkg::ST_SETUP: begin
                if (i_stat.wait_done) begin
                    o_cmd.wait_start = 1'b1;
                    o_cmd.wait_units = dcg_pkg::WAIT_HIGH;
                    n_state          = dcg_pkg::ST_HIGH;
                end
            end
            dcg_pkg::ST_HIGH: begin
                if (i_stat.wait_done) begin
                    o_cmd.wait_start = 1'b1;
                    o_cmd.wait_units = dcg_pkg::WAIT_AFTER;
                    n_state          = dcg_pkg::ST_AFTER;
                end
            end
            dcg_pkg::ST_AFTER: begin
                if (i_stat.wait_done) begin
                    n_state = dcg_pkg::ST_EMIT;
                end
            end
            dcg_pkg::ST_EMIT: begin
                // Hand the event over once the output register can take it.
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_event) begin
                        n_state = dcg_pkg::ST_IDLE;
                    end else begin
                        o_cmd.wait_start = 1'b1;
                        o_cmd.wait_units = dcg_pkg::WAIT_BEFORE;
                        n_state          = dcg_pkg::ST_BEFORE;
                    end
                end
            end
            default: begin
                n_state = dcg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/dcg_datapath.sv
module dcg_datapath #(
    parameter int COLUMNS_PER_CHIP = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  dcg_pkg::t_dp_cmd  i_cmd,
    output dcg_pkg::t_dp_stat o_stat,
    input  dcg_pkg::t_req     i_req,
    input  logic [7:0]        i_value,
    input  logic [1:0]        i_chip_mask,
    input  logic [6:0]        i_x_pos,
    input  logic [5:0]        i_y_pos,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_event_kind,
    output logic              o_reg_select,
    output logic [1:0]        o_chip_select,
    output logic [7:0]        o_bus_byte,
    output logic              o_last_of_run
);

    localparam logic [8:0] COLS = 9'(COLUMNS_PER_CHIP);

    // Delay unit register and wait timer.
    logic [dcg_pkg::DELAY_W-1:0] r_delay;
    logic [dcg_pkg::DELAY_W-1:0] r_cyc;
    logic [dcg_pkg::DELAY_W-1:0] n_cyc;
    logic [dcg_pkg::UNIT_W-1:0]  r_unit_left;
    logic [dcg_pkg::UNIT_W-1:0]  n_unit_left;

    // Held request and position in its run of events.
    dcg_pkg::t_req           r_req;
    logic [7:0]              r_value;
    logic [1:0]              r_mask;
    logic [6:0]              r_x;
    logic [5:0]              r_y;
    logic [dcg_pkg::IDX_W-1:0] r_run_index;

    // Output register.
    logic       r_out_valid;
    logic       r_kind;
    logic       r_rs;
    logic [1:0] r_cs;
    logic [7:0] r_byte;
    logic       r_last;

    // Current event.
    logic       ev_kind;
    logic       ev_rs;
    logic [1:0] ev_cs;
    logic [7:0] ev_byte;
    logic       ev_last;

    // Goto address decode.
    logic [8:0] x_ext;
    logic [8:0] col_ext;
    logic       go_low;
    logic [1:0] go_chip;
    logic [7:0] go_page_byte;
    logic [7:0] go_col_byte;

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= dcg_pkg::DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_data;
        end
    end

    // Wait timer: counts down delay units; r_cyc counts up to r_delay - 1 in each unit.
    always_comb begin
        n_cyc       = r_cyc;
        n_unit_left = r_unit_left;
        if (i_cmd.wait_start) begin
            n_cyc       = '0;
            n_unit_left = i_cmd.wait_units;
        end else if (r_unit_left != '0) begin
            if (r_cyc == r_delay - 16'd1) begin
                n_cyc       = '0;
                n_unit_left = r_unit_left - 4'd1;
            end else begin
                n_cyc = r_cyc + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyc       <= '0;
            r_unit_left <= '0;
        end else begin
            r_cyc       <= n_cyc;
            r_unit_left <= n_unit_left;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_req;
            r_value <= i_value;
            r_mask  <= i_chip_mask;
            r_x     <= i_x_pos;
            r_y     <= i_y_pos;
        end
    end

    // Run index: cleared on a new request, advanced on each emitted event but the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_index <= '0;
        end else if (i_cmd.accept) begin
            r_run_index <= '0;
        end else if (i_cmd.emit && !ev_last) begin
            r_run_index <= r_run_index + 3'd1;
        end
    end

    // Goto: columns below the chip width go to chip 1, the rest to chip 2.
    always_comb begin
        x_ext        = {2'b00, r_x};
        col_ext      = x_ext - COLS;
        go_low       = (x_ext < COLS);
        go_chip      = go_low ? dcg_pkg::CS_CHIP1 : dcg_pkg::CS_CHIP2;
        go_page_byte = dcg_pkg::OP_SET_PAGE | {5'b00000, r_y[5:3]};
        go_col_byte  = dcg_pkg::OP_SET_COLUMN
                     | {2'b00, (go_low ? r_x[5:0] : col_ext[5:0])};
    end

    // Event selection from the request and the run index.
    always_comb begin
        ev_kind = dcg_pkg::EV_WRITE;
        ev_rs   = 1'b0;
        ev_cs   = '0;
        ev_byte = '0;
        ev_last = 1'b0;
        case (r_req)
            dcg_pkg::REQ_INIT: begin
                case (r_run_index)
                    3'd0: begin
                        ev_kind = dcg_pkg::EV_RESET;
                    end
                    3'd1: begin
                        ev_cs   = dcg_pkg::CS_BOTH;
                        ev_byte = dcg_pkg::OP_DISPLAY_ON;
                    end
                    3'd2: begin
                        ev_cs   = dcg_pkg::CS_BOTH;
                        ev_byte = dcg_pkg::OP_START_LINE;
                    end
                    3'd3: begin
                        ev_cs   = dcg_pkg::CS_CHIP1;
                        ev_byte = dcg_pkg::OP_SET_PAGE;
                    end
                    default: begin
                        ev_cs   = dcg_pkg::CS_CHIP1;
                        ev_byte = dcg_pkg::OP_SET_COLUMN;
                        ev_last = 1'b1;
                    end
                endcase
            end
            dcg_pkg::REQ_CMD: begin
                ev_cs   = r_mask;
                ev_byte = r_value;
                ev_last = 1'b1;
            end
            dcg_pkg::REQ_DATA: begin
                ev_rs   = 1'b1;
                ev_cs   = r_mask;
                ev_byte = r_value;
                ev_last = 1'b1;
            end
            dcg_pkg::REQ_GOTO: begin
                ev_cs = go_chip;
                if (r_run_index == '0) begin
                    ev_byte = go_page_byte;
                end else begin
                    ev_byte = go_col_byte;
                    ev_last = 1'b1;
                end
            end
            default: begin
                ev_last = 1'b1;
            end
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind <= ev_kind;
            r_rs   <= ev_rs;
            r_cs   <= ev_cs;
            r_byte <= ev_byte;
            r_last <= ev_last;
        end
    end

    assign o_stat.wait_done  = (r_unit_left == '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_stat.last_event = ev_last;

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_reg_select  = r_rs;
    assign o_chip_select = r_cs;
    assign o_bus_byte    = r_byte;
    assign o_last_of_run = r_last;

    // An event is never loaded over one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("event loaded over a pending beat");

    // A run never goes past the fifth event of an init request.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_index <= dcg_pkg::IDX_INIT_LAST)
        else $error("run index out of range");

    // A timing phase only starts after the previous one has run out.
    a_wait_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wait_start |-> (r_unit_left == '0))
        else $error("wait started while timer busy");

    // A reset pulse event always carries zero bus fields.
    a_reset_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == dcg_pkg::EV_RESET))
            |-> (!r_rs && (r_cs == '0) && (r_byte == '0)))
        else $error("reset pulse with nonzero bus fields");

endmodule

>>> rtl/core/dual_chip_glcd_bus_controller.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_cmd, i_value, i_chip_mask, i_x_pos, i_y_pos
// output    o_out_valid / i_out_ready  o_event_kind, o_reg_select, o_chip_select,
//                                      o_bus_byte, o_last_of_run
// config    i_cfg_we                   i_cfg_data (delay unit cycles)
//
// Each bus event takes 22 delay units (10 before, 1 setup, 1 high, 10 after), then
// a hand-off that loads the output register. The delay unit D is set on the config
// channel. A request holds one to five events; one request is in flight at a time,
// and the wait timer in the datapath sets the length of each phase.
// Reset is synchronous and active low; D returns to 10 and the output is empty.
// A stalled output beat holds the controller in hand-off; a new request is taken
// as soon as the last event of the previous one sits in the output register.
module dual_chip_glcd_bus_controller #(
    parameter int COLUMNS_PER_CHIP = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_value,
    input  logic [1:0]  i_chip_mask,
    input  logic [6:0]  i_x_pos,
    input  logic [5:0]  i_y_pos,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_event_kind,
    output logic        o_reg_select,
    output logic [1:0]  o_chip_select,
    output logic [7:0]  o_bus_byte,
    output logic        o_last_of_run
);

    dcg_pkg::t_dp_cmd  dp_cmd;
    dcg_pkg::t_dp_stat dp_stat;

    // Sequencing of the timing phases.
    dcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    // Request decode, wait timer and output register.
    dcg_datapath #(
        .COLUMNS_PER_CHIP (COLUMNS_PER_CHIP)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_req         (dcg_pkg::t_req'(i_cmd)),
        .i_value       (i_value),
        .i_chip_mask   (i_chip_mask),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_reg_select  (o_reg_select),
        .o_chip_select (o_chip_select),
        .o_bus_byte    (o_bus_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = 64;

    // One bus event as it leaves the output channel.
    typedef struct packed {
        logic       kind;
        logic       rs;
        logic [1:0] cs;
        logic [7:0] data;
        logic       last;
    } t_bus_event;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [15:0] i_cfg_data   = '0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_cmd        = '0;
    logic [7:0]  i_value      = '0;
    logic [1:0]  i_chip_mask  = '0;
    logic [6:0]  i_x_pos      = '0;
    logic [5:0]  i_y_pos      = '0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_event_kind;
    logic        o_reg_select;
    logic [1:0]  o_chip_select;
    logic [7:0]  o_bus_byte;
    logic        o_last_of_run;

    t_bus_event  pending_events[$];
    int          mismatches     = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles   = 0;
    logic [15:0] delay_units    = dcg_pkg::DELAY_RESET;

    dual_chip_glcd_bus_controller #(
        .COLUMNS_PER_CHIP(COLUMNS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_chip_mask   (i_chip_mask),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_reg_select  (o_reg_select),
        .o_chip_select (o_chip_select),
        .o_bus_byte    (o_bus_byte),
        .o_last_of_run (o_last_of_run)
    );

    // A 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_bus_event bus_event(logic kind, logic rs, logic [1:0] cs,
                                             logic [7:0] data, logic last);
        t_bus_event ev;
        ev.kind = kind;
        ev.rs   = rs;
        ev.cs   = cs;
        ev.data = data;
        ev.last = last;
        return ev;
    endfunction

    // A cursor move is a page write then a column write, both to the chip that owns x.
    function automatic void add_cursor_events(logic [6:0] x, logic [5:0] y);
        logic [1:0] cs;
        logic [6:0] col;
        if (x < COLUMNS) begin
            cs  = dcg_pkg::CS_CHIP1;
            col = x;
        end else begin
            cs  = dcg_pkg::CS_CHIP2;
            col = 7'(x - COLUMNS);
        end
        pending_events.push_back(bus_event(dcg_pkg::EV_WRITE, 1'b0, cs,
                                           dcg_pkg::OP_SET_PAGE | {5'd0, y[5:3]}, 1'b0));
        pending_events.push_back(bus_event(dcg_pkg::EV_WRITE, 1'b0, cs,
                                           dcg_pkg::OP_SET_COLUMN | {2'd0, col[5:0]},
                                           1'b1));
    endfunction

    // Expands one request into the bus events it must produce.
    function automatic void predict_bus_events(dcg_pkg::t_req req, logic [7:0] value,
                                               logic [1:0] mask, logic [6:0] x,
                                               logic [5:0] y);
        case (req)
            dcg_pkg::REQ_INIT: begin
                pending_events.push_back(bus_event(dcg_pkg::EV_RESET, 1'b0, 2'b00,
                                                   8'h00, 1'b0));
                pending_events.push_back(bus_event(dcg_pkg::EV_WRITE, 1'b0,
                                                   dcg_pkg::CS_BOTH,
                                                   dcg_pkg::OP_DISPLAY_ON, 1'b0));
                pending_events.push_back(bus_event(dcg_pkg::EV_WRITE, 1'b0,
                                                   dcg_pkg::CS_BOTH,
                                                   dcg_pkg::OP_START_LINE, 1'b0));
                add_cursor_events(7'd0, 6'd0);
            end
            dcg_pkg::REQ_CMD: begin
                pending_events.push_back(bus_event(dcg_pkg::EV_WRITE, 1'b0, mask,
                                                   value, 1'b1));
            end
            dcg_pkg::REQ_DATA: begin
                pending_events.push_back(bus_event(dcg_pkg::EV_WRITE, 1'b1, mask,
                                                   value, 1'b1));
            end
            default: begin
                add_cursor_events(x, y);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // Sends one request beat after a random gap; valid stays high after acceptance.
    task automatic send_request(dcg_pkg::t_req req, logic [7:0] value, logic [1:0] mask,
                                logic [6:0] x, logic [5:0] y, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= req;
        i_value     <= value;
        i_chip_mask <= mask;
        i_x_pos     <= x;
        i_y_pos     <= y;
        predict_bus_events(req, value, mask, x, y);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random_request(int idle_pct);
        send_request(dcg_pkg::t_req'($urandom_range(3)), 8'($urandom_range(255)),
                     2'($urandom_range(3)), 7'($urandom_range(127)),
                     6'($urandom_range(63)), idle_pct);
    endtask

    // Holds the input side until every pending event has come out.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic write_delay(logic [15:0] cycles);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cycles;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        delay_units = cycles;
    endtask

    task automatic run_random_requests(int count, int send_idle_pct, int recv_pct);
        recv_stall_pct = recv_pct;
        for (int n = 1; n <= count; n++) begin
            send_random_request(send_idle_pct);
            if (n % 25 == 0) begin
                wait_for_drain();
            end
        end
        wait_for_drain();
        recv_stall_pct = 0;
    endtask

    // Every request kind and field extreme at the reset delay unit.
    task automatic test_directed_requests();
        send_request(dcg_pkg::REQ_INIT, 8'($urandom_range(255)), 2'($urandom_range(3)),
                     7'($urandom_range(127)), 6'($urandom_range(63)), 0);
        send_request(dcg_pkg::REQ_CMD, 8'h00, 2'b00, 7'h7F, 6'h3F, 0);
        send_request(dcg_pkg::REQ_CMD, 8'hFF, dcg_pkg::CS_BOTH, 7'h00, 6'h00, 0);
        send_request(dcg_pkg::REQ_CMD, 8'hA5, dcg_pkg::CS_CHIP1, 7'h55, 6'h2A, 0);
        send_request(dcg_pkg::REQ_CMD, 8'h5A, dcg_pkg::CS_CHIP2, 7'h2A, 6'h15, 0);
        send_request(dcg_pkg::REQ_DATA, 8'h00, 2'b00, 7'h7F, 6'h3F, 0);
        send_request(dcg_pkg::REQ_DATA, 8'hFF, dcg_pkg::CS_BOTH, 7'h00, 6'h00, 0);
        send_request(dcg_pkg::REQ_DATA, 8'h3C, dcg_pkg::CS_CHIP1, 7'h40, 6'h08, 0);
        send_request(dcg_pkg::REQ_DATA, 8'hC3, dcg_pkg::CS_CHIP2, 7'h3F, 6'h07, 0);
        send_request(dcg_pkg::REQ_GOTO, 8'hFF, dcg_pkg::CS_BOTH, 7'd0, 6'd0, 0);
        send_request(dcg_pkg::REQ_GOTO, 8'h00, 2'b00, 7'd63, 6'd7, 0);
        send_request(dcg_pkg::REQ_GOTO, 8'h81, dcg_pkg::CS_CHIP1, 7'd64, 6'd8, 0);
        send_request(dcg_pkg::REQ_GOTO, 8'h7E, dcg_pkg::CS_CHIP2, 7'd127, 6'd63, 0);
        send_request(dcg_pkg::REQ_GOTO, 8'h11, 2'b00, 7'd100, 6'd40, 0);
        send_request(dcg_pkg::REQ_GOTO, 8'hEE, dcg_pkg::CS_BOTH, 7'd31, 6'd55, 0);
        send_request(dcg_pkg::REQ_INIT, 8'hFF, dcg_pkg::CS_BOTH, 7'h7F, 6'h3F, 0);
        wait_for_drain();
    endtask

    // Shortest delay unit, first back to back, then with a sparse sender.
    task automatic test_fastest_timing();
        write_delay(16'd1);
        run_random_requests(100, 0, 0);
        run_random_requests(100, 74, 0);
    endtask

    task automatic test_receiver_stalls();
        write_delay(16'd2);
        run_random_requests(100, 0, 74);
    endtask

    task automatic test_light_idling_both_sides();
        write_delay(16'd3);
        run_random_requests(60, 6, 6);
    endtask

    // Longest delay unit: a single one-event request exercises the full wait counter.
    task automatic test_slowest_timing();
        write_delay(16'hFFFF);
        send_request(dcg_pkg::REQ_DATA, 8'($urandom_range(255)), 2'($urandom_range(3)),
                     7'($urandom_range(127)), 6'($urandom_range(63)), 0);
        wait_for_drain();
    endtask

    task automatic test_reset_delay_again();
        write_delay(dcg_pkg::DELAY_RESET);
        run_random_requests(30, 0, 0);
    endtask

    // The receiver drops ready at random in stalling phases.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each output beat with the oldest pending event.
    always @(posedge i_clk) begin : check_beats
        t_bus_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("beat with nothing pending, bus byte", o_bus_byte, 0);
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind)
                    report_mismatch("event kind", o_event_kind, want.kind);
                if (o_reg_select !== want.rs)
                    report_mismatch("reg select", o_reg_select, want.rs);
                if (o_chip_select !== want.cs)
                    report_mismatch("chip select", o_chip_select, want.cs);
                if (o_bus_byte !== want.data)
                    report_mismatch("bus byte", o_bus_byte, want.data);
                if (o_last_of_run !== want.last)
                    report_mismatch("last of run", o_last_of_run, want.last);
            end
        end
    end

    // Ends the run with a mismatch verdict when no beat moves on either channel past the quiet limit.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 4 * (22 * int'(delay_units) + 5) + 4000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_requests();
        test_fastest_timing();
        test_receiver_stalls();
        test_light_idling_both_sides();
        test_slowest_timing();
        test_reset_delay_again();

        // Leave room for any stray event before the verdict.
        wait_for_drain();
        repeat (24 * int'(delay_units) + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
